>>> sv/wavp_pkg.sv
// Shared types and constants of the WAV header and sample parser.
// Holds tags, format codes, result/error codes and the control/status structs.
// No dependencies.
package wavp_pkg;

  // Tags as they sit in the 32-bit assembly register (first byte lowest)
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;

  localparam logic [15:0] FmtPcm   = 16'h0001;
  localparam logic [15:0] FmtFloat = 16'h0003;

  // Restoring divider steps, one quotient bit each
  localparam int DivSteps = 32;
  localparam int DivisorW = 29;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NOT_RIFF     = 2'd0,
    ERR_NOT_WAVE_FMT = 2'd1,
    ERR_FORMAT       = 2'd2,
    ERR_ZERO_DIV     = 2'd3
  } err_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  shift;
    logic  load_format;
    logic  load_channels;
    logic  load_rate;
    logic  load_bps;
    logic  div_start;
    logic  emit;
    kind_e emit_kind;
    err_e  emit_code;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic tag_riff;
    logic tag_wave;
    logic tag_fmt;
    logic fmt_pcm;
    logic fmt_float;
    logic zero_div;
    logic div_done;
    logic frames_zero;
    logic last_sample;
  } sts_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  error_code;
    logic        is_float;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] frame_count;
    logic [31:0] frame_index;
    logic [15:0] channel_index;
    logic [31:0] sample_bits;
    logic        last_sample;
  } result_t;

endpackage

>>> sv/wavp_if.sv
// Channel interfaces of the WAV parser: byte input and result output.
// Each carries valid, ready and the payload; depends on nothing.
interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       file_start;

  modport source (output valid, output stream_byte, output file_start, input ready);
  modport sink   (input valid, input stream_byte, input file_start, output ready);
endinterface

interface wavp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [1:0]  error_code;
  logic        is_float;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] frame_count;
  logic [31:0] frame_index;
  logic [15:0] channel_index;
  logic [31:0] sample_bits;
  logic        last_sample;

  modport source (
    output valid, input ready,
    output result_kind, output error_code, output is_float, output channel_count,
    output sample_rate, output frame_count, output frame_index, output channel_index,
    output sample_bits, output last_sample
  );
  modport sink (
    input valid, output ready,
    input result_kind, input error_code, input is_float, input channel_count,
    input sample_rate, input frame_count, input frame_index, input channel_index,
    input sample_bits, input last_sample
  );
endinterface

>>> sv/wavp_div.sv
// Restoring divider, one quotient bit per cycle, for the frame count.
// Depends on wavp_pkg for the step count and divisor width.
module wavp_div
  import wavp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         dividend_i,
  input  logic [DivisorW-1:0] divisor_i,
  output logic                done_o,
  output logic [31:0]         quotient_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] dvs_q, dvs_d;
  logic [31:0]         quo_q, quo_d;
  logic [DivisorW:0]   partial;
  logic [DivisorW+1:0] diff;

  // Trial subtract of the divisor from the shifted partial remainder
  assign partial = {rem_q, quo_q[31]};
  assign diff    = {1'b0, partial} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (!diff[DivisorW+1]) begin
        rem_d = diff[DivisorW-1:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = partial[DivisorW-1:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> sv/wavp_dp.sv
// Datapath of the WAV parser: byte assembly, fmt fields, counters, result register.
// Depends on wavp_pkg and instantiates wavp_div for the frame count.
module wavp_dp
  import wavp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] stream_byte_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output result_t    res_o
);

  logic [31:0]         shift_q, shift_next;
  logic [15:0]         format_q;
  logic [15:0]         chan_q;
  logic [31:0]         rate_q;
  logic [15:0]         bps_q;
  logic [31:0]         frames_q;
  logic [31:0]         frame_cnt_q;
  logic [15:0]         chan_cnt_q;
  result_t             res_q, res_d;
  logic [DivisorW-1:0] divisor;
  logic                div_done;
  logic [31:0]         quotient;
  logic                is_float;
  logic                last_chan;
  logic                last_frame;
  logic [31:0]         sample_val;

  // Newest byte enters at the top, as the stream is little-endian
  assign shift_next = {stream_byte_i, shift_q[31:8]};

  // Frames = size / (bits/8) / channels, taken as one division by the product
  assign divisor = {16'b0, bps_q[15:3]} * {13'b0, chan_q};

  wavp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (shift_next),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign is_float   = (format_q == FmtFloat);
  assign last_chan  = ({1'b0, chan_cnt_q} + 17'd1) >= {1'b0, chan_q};
  assign last_frame = ({1'b0, frame_cnt_q} + 33'd1) >= {1'b0, frames_q};
  assign sample_val = is_float ? shift_next : {{16{shift_next[31]}}, shift_next[31:16]};

  // Status for the controller
  always_comb begin
    sts_o.tag_riff    = (shift_next == TagRiff);
    sts_o.tag_wave    = (shift_next == TagWave);
    sts_o.tag_fmt     = (shift_next == TagFmt);
    sts_o.fmt_pcm     = (format_q == FmtPcm);
    sts_o.fmt_float   = is_float;
    sts_o.zero_div    = (bps_q[15:3] == 13'd0) || (chan_q == 16'd0);
    sts_o.div_done    = div_done;
    sts_o.frames_zero = (quotient == 32'd0);
    sts_o.last_sample = last_chan && last_frame;
  end

  // Build the next result transaction
  always_comb begin
    res_d = res_q;
    if (cmd_i.emit) begin
      res_d             = '0;
      res_d.result_kind = cmd_i.emit_kind;
      unique case (cmd_i.emit_kind)
        KIND_HEADER: begin
          res_d.is_float      = is_float;
          res_d.channel_count = chan_q;
          res_d.sample_rate   = rate_q;
          res_d.frame_count   = quotient;
        end
        KIND_SAMPLE: begin
          res_d.is_float      = is_float;
          res_d.channel_count = chan_q;
          res_d.sample_rate   = rate_q;
          res_d.frame_count   = frames_q;
          res_d.frame_index   = frame_cnt_q;
          res_d.channel_index = chan_cnt_q;
          res_d.sample_bits   = sample_val;
          res_d.last_sample   = last_chan && last_frame;
        end
        KIND_ERROR: begin
          res_d.error_code = cmd_i.emit_code;
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  // Assembly register, fmt fields and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      shift_q <= shift_next;
    end
    if (cmd_i.load_format) begin
      format_q <= shift_next[31:16];
    end
    if (cmd_i.load_channels) begin
      chan_q <= shift_next[31:16];
    end
    if (cmd_i.load_rate) begin
      rate_q <= shift_next;
    end
    if (cmd_i.load_bps) begin
      bps_q <= shift_next[31:16];
    end
    res_q <= res_d;
  end

  // Frame and channel counters: clear at the header, advance per sample
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && (cmd_i.emit_kind == KIND_HEADER)) begin
      frames_q    <= quotient;
      frame_cnt_q <= '0;
      chan_cnt_q  <= '0;
    end else if (cmd_i.emit && (cmd_i.emit_kind == KIND_SAMPLE)) begin
      if (last_chan) begin
        chan_cnt_q  <= '0;
        frame_cnt_q <= frame_cnt_q + 32'd1;
      end else begin
        chan_cnt_q <= chan_cnt_q + 16'd1;
      end
    end
  end

  assign res_o = res_q;

endmodule

>>> sv/wavp_ctrl.sv
// Controller of the WAV parser: parse phase, byte position and handshakes.
// Depends on wavp_pkg; drives the datapath through cmd_t, reads sts_t.
module wavp_ctrl
  import wavp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_file_start_i,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  localparam logic [2:0] PhRiff    = 3'd0;
  localparam logic [2:0] PhRsize   = 3'd1;
  localparam logic [2:0] PhWaveFmt = 3'd2;
  localparam logic [2:0] PhFields  = 3'd3;
  localparam logic [2:0] PhFloatX  = 3'd4;
  localparam logic [2:0] PhDataHdr = 3'd5;
  localparam logic [2:0] PhSamples = 3'd6;
  localparam logic [2:0] PhIdle    = 3'd7;

  // Byte positions within each phase
  localparam logic [4:0] PosTagEnd   = 5'd3;
  localparam logic [4:0] PosFmtEnd   = 5'd7;
  localparam logic [4:0] PosFormat   = 5'd5;
  localparam logic [4:0] PosChannels = 5'd7;
  localparam logic [4:0] PosRate     = 5'd11;
  localparam logic [4:0] PosBps      = 5'd19;
  localparam logic [4:0] PosFloatEnd = 5'd13;
  localparam logic [4:0] PosSizeEnd  = 5'd7;
  localparam logic [4:0] PosPcmLast  = 5'd1;
  localparam logic [4:0] PosFltLast  = 5'd3;

  logic [2:0] phase_q, phase_d, phase_eff;
  logic [4:0] pos_q, pos_d, pos_eff;
  logic       tag_bad_q, tag_bad_d, tag_bad_eff;
  logic       wait_q, wait_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !wait_q && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // A file start restarts the parse with this byte
  assign phase_eff   = in_file_start_i ? PhRiff : phase_q;
  assign pos_eff     = in_file_start_i ? 5'd0 : pos_q;
  assign tag_bad_eff = in_file_start_i ? 1'b0 : tag_bad_q;

  always_comb begin
    cmd_o     = '0;
    phase_d   = phase_q;
    pos_d     = pos_q;
    tag_bad_d = tag_bad_q;
    wait_d    = wait_q;
    if (wait_q) begin
      // Hold until the quotient is in and the output register is free
      if (sts_i.div_done && out_free) begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = KIND_HEADER;
        wait_d          = 1'b0;
        phase_d         = sts_i.frames_zero ? PhIdle : PhSamples;
      end
    end else if (accept) begin
      phase_d   = phase_eff;
      pos_d     = pos_eff;
      tag_bad_d = tag_bad_eff;
      if (phase_eff != PhIdle) begin
        cmd_o.shift = 1'b1;
        pos_d       = pos_eff + 5'd1;
        unique case (phase_eff)
          PhRiff: begin
            if (pos_eff == PosTagEnd) begin
              pos_d = '0;
              if (!sts_i.tag_riff) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = KIND_ERROR;
                cmd_o.emit_code = ERR_NOT_RIFF;
                phase_d         = PhIdle;
              end else begin
                phase_d = PhRsize;
              end
            end
          end
          PhRsize: begin
            if (pos_eff == PosTagEnd) begin
              pos_d   = '0;
              phase_d = PhWaveFmt;
            end
          end
          PhWaveFmt: begin
            if (pos_eff == PosTagEnd) begin
              tag_bad_d = !sts_i.tag_wave;
            end else if (pos_eff == PosFmtEnd) begin
              pos_d = '0;
              if (tag_bad_eff || !sts_i.tag_fmt) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = KIND_ERROR;
                cmd_o.emit_code = ERR_NOT_WAVE_FMT;
                phase_d         = PhIdle;
              end else begin
                phase_d = PhFields;
              end
            end
          end
          PhFields: begin
            cmd_o.load_format   = (pos_eff == PosFormat);
            cmd_o.load_channels = (pos_eff == PosChannels);
            cmd_o.load_rate     = (pos_eff == PosRate);
            cmd_o.load_bps      = (pos_eff == PosBps);
            if (pos_eff == PosBps) begin
              pos_d = '0;
              if (!sts_i.fmt_pcm && !sts_i.fmt_float) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = KIND_ERROR;
                cmd_o.emit_code = ERR_FORMAT;
                phase_d         = PhIdle;
              end else begin
                phase_d = sts_i.fmt_float ? PhFloatX : PhDataHdr;
              end
            end
          end
          PhFloatX: begin
            if (pos_eff == PosFloatEnd) begin
              pos_d   = '0;
              phase_d = PhDataHdr;
            end
          end
          PhDataHdr: begin
            if (pos_eff == PosSizeEnd) begin
              pos_d = '0;
              if (sts_i.zero_div) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = KIND_ERROR;
                cmd_o.emit_code = ERR_ZERO_DIV;
                phase_d         = PhIdle;
              end else begin
                cmd_o.div_start = 1'b1;
                wait_d          = 1'b1;
              end
            end
          end
          PhSamples: begin
            if (pos_eff == (sts_i.fmt_float ? PosFltLast : PosPcmLast)) begin
              pos_d           = '0;
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = KIND_SAMPLE;
              if (sts_i.last_sample) begin
                phase_d = PhIdle;
              end
            end
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
    end
  end

  // Output valid: set on a new result, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhRiff;
      pos_q       <= '0;
      tag_bad_q   <= 1'b0;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      tag_bad_q   <= tag_bad_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/wav_header_and_sample_parser.sv
// Top level of the WAV header and sample parser.
// Depends on wavp_pkg, wavp_if, wavp_ctrl and wavp_dp.
//
//  channel  dir  payload                                        transaction
//  in_i     in   stream_byte, file_start                        one file byte
//  out_o    out  result_kind, error_code, is_float, counts,     header, sample
//                rate, frame/channel index, sample_bits, last    or error
//
// One byte is taken per cycle while the result register is free and no divide runs.
// The data size byte starts a bit-serial divide for the frame count;
// input stalls until the quotient is in and the header result leaves.
// A result waiting in the output register holds input until it is taken.
// Reset (rst_ni low, asynchronous) returns the parser to the RIFF tag.
module wav_header_and_sample_parser
  import wavp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  wavp_in_if.sink   in_i,
  wavp_out_if.source out_o
);

  cmd_t    cmd;
  sts_t    sts;
  result_t res;

  wavp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_file_start_i (in_i.file_start),
    .out_ready_i     (out_o.ready),
    .sts_i           (sts),
    .in_ready_o      (in_i.ready),
    .out_valid_o     (out_o.valid),
    .cmd_o           (cmd)
  );

  wavp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stream_byte_i (in_i.stream_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .res_o         (res)
  );

  // Drive the result payload
  assign out_o.result_kind   = res.result_kind;
  assign out_o.error_code    = res.error_code;
  assign out_o.is_float      = res.is_float;
  assign out_o.channel_count = res.channel_count;
  assign out_o.sample_rate   = res.sample_rate;
  assign out_o.frame_count   = res.frame_count;
  assign out_o.frame_index   = res.frame_index;
  assign out_o.channel_index = res.channel_index;
  assign out_o.sample_bits   = res.sample_bits;
  assign out_o.last_sample   = res.last_sample;

endmodule

>>> sv/wavp_checker.sv
// Port-level checker for the WAV parser, bound to the top level.
// Depends on wavp_pkg for the result and error codes.
module wavp_checker
  import wavp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_i,
  input logic [1:0]  error_code_i,
  input logic        is_float_i,
  input logic [15:0] channel_count_i,
  input logic [31:0] sample_rate_i,
  input logic [31:0] frame_count_i,
  input logic [31:0] frame_index_i,
  input logic [15:0] channel_index_i,
  input logic [31:0] sample_bits_i,
  input logic        last_sample_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(result_kind_i) && $stable(sample_bits_i))
    else $error("stalled result changed");

  // Take a byte only when the result register can take its result
  a_in_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("byte accepted while result register blocked");

  // Error results carry nothing but the code
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == KIND_ERROR) |->
      !is_float_i && (channel_count_i == 16'd0) && (sample_rate_i == 32'd0) &&
      (frame_count_i == 32'd0) && !last_sample_i)
    else $error("error result carries payload");

  // Non-error results carry a zero code
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i != KIND_ERROR) |-> error_code_i == 2'd0)
    else $error("error code set on non-error result");

  // The last sample closes the last channel of the last frame
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == KIND_SAMPLE) && last_sample_i |->
      (frame_index_i == frame_count_i - 32'd1) &&
      (channel_index_i == channel_count_i - 16'd1))
    else $error("last sample flagged at wrong position");

endmodule

bind wav_header_and_sample_parser wavp_checker u_wavp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .result_kind_i   (out_o.result_kind),
  .error_code_i    (out_o.error_code),
  .is_float_i      (out_o.is_float),
  .channel_count_i (out_o.channel_count),
  .sample_rate_i   (out_o.sample_rate),
  .frame_count_i   (out_o.frame_count),
  .frame_index_i   (out_o.frame_index),
  .channel_index_i (out_o.channel_index),
  .sample_bits_i   (out_o.sample_bits),
  .last_sample_i   (out_o.last_sample)
);

>>> test/testbench.sv
// Self-checking testbench of the WAV header and sample parser.
// Depends on wavp_pkg, wavp_in_if/wavp_out_if and the RTL top; feeds byte streams
// of well-formed, broken and noise files and checks every result against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wavp_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int LiveTarget  = 2000;
  localparam int QuietFrom   = 1700;
  localparam int LongHold    = 500;
  localparam int DrainCycles = 80;

  // Tags seen as 32-bit little-endian words
  localparam logic [31:0] TagFact = 32'h7463_6166;
  localparam logic [31:0] TagData = 32'h6174_6164;

  typedef enum logic [3:0] {
    ST_RIFF, ST_RIFF_SIZE, ST_TAGS, ST_FIELDS, ST_FLOAT_EXTRA, ST_DATA_HDR, ST_SAMPLES, ST_DONE
  } parse_phase_e;

  // Predicts parser results byte by byte and checks the ones the block emits
  class wav_parse_tracker;
    parse_phase_e phase;
    logic [5:0]   pos;
    logic [31:0]  shift;
    logic [15:0]  fmt_code;
    logic [15:0]  chans;
    logic [31:0]  rate;
    logic [15:0]  bps;
    logic [31:0]  frames;
    logic [31:0]  frame_no;
    logic [15:0]  chan_no;
    logic         wave_bad;
    result_t      pending[$];
    int           errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      phase    = ST_RIFF;
      pos      = '0;
      shift    = '0;
      fmt_code = '0;
      chans    = '0;
      rate     = '0;
      bps      = '0;
      frames   = '0;
      frame_no = '0;
      chan_no  = '0;
      wave_bad = 1'b0;
    endfunction

    function void give_error(err_e code);
      result_t r;
      r = '0;
      r.result_kind = KIND_ERROR;
      r.error_code  = code;
      pending.push_back(r);
      phase = ST_DONE;
    endfunction

    function result_t stream_info(kind_e kind);
      result_t r;
      r = '0;
      r.result_kind   = kind;
      r.is_float      = (fmt_code == FmtFloat);
      r.channel_count = chans;
      r.sample_rate   = rate;
      r.frame_count   = frames;
      return r;
    endfunction

    // Advance the parse by one accepted byte; return 0 when the byte is ignored
    function bit take_byte(logic [7:0] b, logic start);
      logic [5:0]  at;
      logic [31:0] unit;
      logic        last_ch;
      logic        last_one;
      result_t     r;
      if (start) clear();
      if (phase == ST_DONE) return 1'b0;
      shift = {b, shift[31:8]};
      at    = pos;
      pos   = pos + 6'd1;
      case (phase)
        ST_RIFF: begin
          if (at == 6'd3) begin
            if (shift != TagRiff) give_error(ERR_NOT_RIFF);
            else begin
              phase = ST_RIFF_SIZE;
              pos   = '0;
            end
          end
        end
        ST_RIFF_SIZE: begin
          if (at == 6'd3) begin
            phase = ST_TAGS;
            pos   = '0;
          end
        end
        // WAVE mismatch is held and reported together with the fmt check
        ST_TAGS: begin
          if (at == 6'd3) wave_bad = (shift != TagWave);
          else if (at == 6'd7) begin
            if (wave_bad || shift != TagFmt) give_error(ERR_NOT_WAVE_FMT);
            else begin
              phase = ST_FIELDS;
              pos   = '0;
            end
          end
        end
        ST_FIELDS: begin
          if (at == 6'd5) fmt_code = shift[31:16];
          else if (at == 6'd7) chans = shift[31:16];
          else if (at == 6'd11) rate = shift;
          else if (at == 6'd19) begin
            bps = shift[31:16];
            if (fmt_code != FmtPcm && fmt_code != FmtFloat) give_error(ERR_FORMAT);
            else begin
              phase = (fmt_code == FmtFloat) ? ST_FLOAT_EXTRA : ST_DATA_HDR;
              pos   = '0;
            end
          end
        end
        ST_FLOAT_EXTRA: begin
          if (at == 6'd13) begin
            phase = ST_DATA_HDR;
            pos   = '0;
          end
        end
        ST_DATA_HDR: begin
          if (at == 6'd7) begin
            unit = {19'b0, bps[15:3]};
            if (unit == 0 || chans == 0) give_error(ERR_ZERO_DIV);
            else begin
              frames   = shift / unit / {16'b0, chans};
              frame_no = '0;
              chan_no  = '0;
              pos      = '0;
              phase    = (frames == 0) ? ST_DONE : ST_SAMPLES;
              pending.push_back(stream_info(KIND_HEADER));
            end
          end
        end
        ST_SAMPLES: begin
          if (at == ((fmt_code == FmtFloat) ? 6'd3 : 6'd1)) begin
            pos = '0;
            r = stream_info(KIND_SAMPLE);
            r.frame_index   = frame_no;
            r.channel_index = chan_no;
            r.sample_bits   = (fmt_code == FmtFloat) ? shift : {{16{shift[31]}}, shift[31:16]};
            last_ch  = ({16'b0, chan_no} + 32'd1) >= {16'b0, chans};
            last_one = last_ch && ((frame_no + 32'd1) >= frames);
            r.last_sample = last_one;
            pending.push_back(r);
            if (last_one) phase = ST_DONE;
            else if (last_ch) begin
              chan_no  = '0;
              frame_no = frame_no + 32'd1;
            end else begin
              chan_no = chan_no + 16'd1;
            end
          end
        end
        default: phase = ST_DONE;
      endcase
      return 1'b1;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Compare one result transaction with the oldest prediction
    task match_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result kind %0d with nothing pending", got.result_kind));
        return;
      end
      want = pending.pop_front();
      check_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
      check_field("error_code", 32'(got.error_code), 32'(want.error_code));
      check_field("is_float", 32'(got.is_float), 32'(want.is_float));
      check_field("channel_count", 32'(got.channel_count), 32'(want.channel_count));
      check_field("sample_rate", got.sample_rate, want.sample_rate);
      check_field("frame_count", got.frame_count, want.frame_count);
      check_field("frame_index", got.frame_index, want.frame_index);
      check_field("channel_index", 32'(got.channel_index), 32'(want.channel_index));
      check_field("sample_bits", got.sample_bits, want.sample_bits);
      check_field("last_sample", 32'(got.last_sample), 32'(want.last_sample));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic idle_on;
  logic hold_request;
  int   live_bytes;
  logic [7:0] file_q[$];
  wav_parse_tracker tracker;

  wavp_in_if  in_if ();
  wavp_out_if out_if ();

  wav_header_and_sample_parser u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // End the run if it stalls
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Observe both channels at the edge; input first so predictions precede results
  always @(posedge clk) begin : watch
    result_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        if (tracker.take_byte(in_if.stream_byte, in_if.file_start)) live_bytes++;
      end
      if (out_if.valid && out_if.ready) begin
        got.result_kind   = out_if.result_kind;
        got.error_code    = out_if.error_code;
        got.is_float      = out_if.is_float;
        got.channel_count = out_if.channel_count;
        got.sample_rate   = out_if.sample_rate;
        got.frame_count   = out_if.frame_count;
        got.frame_index   = out_if.frame_index;
        got.channel_index = out_if.channel_index;
        got.sample_bits   = out_if.sample_bits;
        got.last_sample   = out_if.last_sample;
        tracker.match_result(got);
      end
    end
  end

  // Result receiver: random stall bursts, and one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_random(int n);
    for (int i = 0; i < n; i++) file_q.push_back(8'($urandom));
  endfunction

  function automatic void shrink(int n);
    while (file_q.size() > n) void'(file_q.pop_back());
  endfunction

  // Build a file header up to and including the data size
  function automatic void make_header(logic [31:0] riff_tag, logic [31:0] wave_tag,
                                      logic [31:0] fmt_tag, logic [15:0] fmt,
                                      logic [15:0] ch, logic [31:0] srate,
                                      logic [15:0] bits, logic [31:0] size);
    file_q.delete();
    put_le(riff_tag, 4);
    put_le($urandom, 4);
    put_le(wave_tag, 4);
    put_le(fmt_tag, 4);
    put_le((fmt == FmtFloat) ? 32'd18 : 32'd16, 4);
    put_le(fmt, 2);
    put_le(ch, 2);
    put_le(srate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(bits, 2);
    if (fmt == FmtFloat) begin
      put_le($urandom, 2);
      put_le(TagFact, 4);
      put_le($urandom, 4);
      put_le($urandom, 4);
    end
    put_le(TagData, 4);
    put_le(size, 4);
  endfunction

  // Mostly well-formed files with small frame counts; some broken, some noise
  function automatic void random_file();
    logic [15:0] fmt;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [31:0] stride;
    logic [31:0] size;
    logic [63:0] body;
    int          frames_want;
    if ($urandom_range(0, 14) == 0) begin
      file_q.delete();
      add_random($urandom_range(1, 20));
      return;
    end
    fmt = ($urandom_range(0, 2) == 0) ? FmtFloat : FmtPcm;
    case ($urandom_range(0, 15))
      0: fmt = 16'hFFFE;
      1: fmt = 16'($urandom);
      default: ;
    endcase
    ch = 16'($urandom_range(1, 4));
    case ($urandom_range(0, 19))
      0: ch = '0;
      1: ch = 16'($urandom);
      default: ;
    endcase
    bits = (fmt == FmtFloat) ? 16'd32 : 16'd16;
    case ($urandom_range(0, 11))
      0: bits = 16'($urandom_range(0, 7));
      1: bits = 16'($urandom);
      2: bits = 16'($urandom_range(8, 40));
      default: ;
    endcase
    stride = {19'b0, bits[15:3]} * {16'b0, ch};
    frames_want = $urandom_range(0, 6);
    size = stride * frames_want;
    if (stride > 1) size = size + $urandom_range(0, stride - 1);
    if ($urandom_range(0, 19) == 0) size = $urandom;
    make_header(TagRiff, TagWave, TagFmt, fmt, ch, $urandom, bits, size);
    if ($urandom_range(0, 9) == 0) file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
    body = 64'(frames_want) * 64'(ch) * ((fmt == FmtFloat) ? 64'd4 : 64'd2);
    if (body > 64) body = 64;
    add_random(int'(body) + $urandom_range(0, 4));
    if ($urandom_range(0, 19) == 0) shrink($urandom_range(1, file_q.size()));
  endfunction

  // Offer one byte and hold it until the parser takes it
  task automatic send_byte(logic [7:0] b, logic start);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.stream_byte <= b;
    in_if.file_start  <= start;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_file(logic start);
    foreach (file_q[i]) send_byte(file_q[i], (i == 0) ? start : 1'b0);
  endtask

  initial begin
    tracker      = new();
    live_bytes   = 0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.stream_byte <= '0;
    in_if.file_start  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // First file without a start flag; most negative PCM sample, trailing bytes ignored
    make_header(TagRiff, TagWave, TagFmt, FmtPcm, 16'd1, 32'd0, 16'd16, 32'd2);
    put_le(32'h8000, 2);
    add_random(2);
    send_file(1'b0);
    // Bad RIFF tag
    make_header(32'h5849_4952, TagWave, TagFmt, FmtPcm, 16'd1, 32'd0, 16'd16, 32'd2);
    shrink(6);
    send_file(1'b1);
    // Bad WAVE tag with a good fmt tag, then bad fmt tag
    make_header(TagRiff, 32'h4556_4158, TagFmt, FmtPcm, 16'd1, 32'd0, 16'd16, 32'd2);
    shrink(16);
    send_file(1'b1);
    make_header(TagRiff, TagWave, 32'h2074_6D67, FmtPcm, 16'd1, 32'd0, 16'd16, 32'd2);
    shrink(16);
    send_file(1'b1);
    // Unsupported formats, extreme field values
    make_header(TagRiff, TagWave, TagFmt, 16'hFFFE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, '1);
    send_file(1'b1);
    make_header(TagRiff, TagWave, TagFmt, 16'h0000, 16'd2, 32'd44100, 16'd16, 32'd8);
    send_file(1'b1);
    // Zero divisor: bits below 8, then zero channels
    make_header(TagRiff, TagWave, TagFmt, FmtPcm, 16'd2, 32'd8000, 16'd7, 32'd16);
    send_file(1'b1);
    make_header(TagRiff, TagWave, TagFmt, FmtFloat, 16'd0, 32'd8000, 16'd32, 32'd16);
    send_file(1'b1);
    // Empty data: header only, following bytes ignored
    make_header(TagRiff, TagWave, TagFmt, FmtPcm, 16'd2, 32'd48000, 16'd16, 32'd3);
    add_random(4);
    send_file(1'b1);
    // Float, two channels, extreme words
    make_header(TagRiff, TagWave, TagFmt, FmtFloat, 16'd2, 32'd96000, 16'd32, 32'd8);
    put_le(32'hFFFF_FFFF, 4);
    put_le(32'h0000_0000, 4);
    send_file(1'b1);
    // PCM, three channels, truncated frame count, extreme samples
    make_header(TagRiff, TagWave, TagFmt, FmtPcm, 16'd3, 32'hFFFF_FFFF, 16'd16, 32'd13);
    put_le(32'h7FFF, 2);
    put_le(32'h8000, 2);
    put_le(32'hFFFF, 2);
    put_le(32'h0000, 2);
    put_le(32'h0001, 2);
    put_le(32'h7FFE, 2);
    add_random(3);
    send_file(1'b1);
    // Huge frame count and channel count, cut short by the next file
    make_header(TagRiff, TagWave, TagFmt, FmtPcm, 16'd1, 32'd1, 16'd8, 32'hFFFF_FFFF);
    add_random(12);
    send_file(1'b1);
    make_header(TagRiff, TagWave, TagFmt, FmtPcm, 16'hFFFF, 32'd2, 16'd16, 32'd131070);
    add_random(20);
    send_file(1'b1);

    // Random files; the receiver holds off at the start so the parser backs up
    hold_request = 1'b1;
    while (live_bytes < LiveTarget) begin
      idle_on = (live_bytes < QuietFrom) && ($urandom_range(0, 3) != 0);
      random_file();
      send_file($urandom_range(0, 15) != 0);
    end
    idle_on = 1'b0;
    in_if.valid <= 1'b0;

    // Drain, then let any trailing work settle
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    // Flag predictions that never got their result
    if (tracker.pending.size() != 0) begin
      tracker.report($sformatf("%0d results never arrived", tracker.pending.size()));
    end
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> wav_header_and_sample_parser.f
sv/wavp_pkg.sv
sv/wavp_if.sv
sv/wavp_div.sv
sv/wavp_dp.sv
sv/wavp_ctrl.sv
sv/wav_header_and_sample_parser.sv
sv/wavp_checker.sv
test/testbench.sv
